@@ rtl/core/ggh_pkg.sv @@
// shared types, constants and the arctangent table of the go-to-goal heading controller
package ggh_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN = 24;
  localparam int CORDIC_RUN = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int PIPE_LAT = CORDIC_RUN + 3;

  localparam int POS_W = 24;
  localparam int HDG_W = 16;
  localparam int SPD_W = 15;
  localparam int DIST_W = 23;
  localparam int VEC_W = 28;
  localparam int MAG_W = 27;
  localparam int ANG_W = 24;
  localparam int GAIN_W = 16;
  localparam int PROD_W = MAG_W + GAIN_W;
  localparam int CFG_W = 24;

  localparam logic signed [ANG_W-1:0] PI_Q20 = 24'sd3294199;
  localparam logic signed [HDG_W-1:0] PI_Q12 = 16'sd12868;
  localparam logic signed [HDG_W-1:0] TWO_PI_Q12 = 16'sd25736;
  localparam logic [GAIN_W-1:0] INV_GAIN_Q16 = 16'd39797;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_TARGET_X = 3'd0;
  localparam reg_idx_t REG_TARGET_Y = 3'd1;
  localparam reg_idx_t REG_MAX_TURN = 3'd2;
  localparam reg_idx_t REG_MIN_TURN = 3'd3;
  localparam reg_idx_t REG_NEAR_DIST = 3'd4;
  localparam reg_idx_t REG_ALIGNED = 3'd5;
  localparam reg_idx_t REG_FAST = 3'd6;
  localparam reg_idx_t REG_SLOW = 3'd7;

  typedef struct packed {
    logic signed [POS_W-1:0] target_x;
    logic signed [POS_W-1:0] target_y;
    logic [SPD_W-1:0]        max_turn_rate;
    logic [SPD_W-1:0]        min_turn_rate;
    logic [DIST_W-1:0]       near_distance;
    logic [SPD_W-1:0]        aligned_error;
    logic [SPD_W-1:0]        fast_speed;
    logic [SPD_W-1:0]        slow_speed;
  } cfg_t;

  typedef struct packed {
    logic                    valid;
    logic                    on_goal;
    logic signed [HDG_W-1:0] hdg;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } vec_t;

  function automatic logic signed [ANG_W-1:0] atan_q20(input int step);
    logic signed [ANG_W-1:0] a;
    case (step)
      0:  a = 24'sd823550;
      1:  a = 24'sd486170;
      2:  a = 24'sd256879;
      3:  a = 24'sd130396;
      4:  a = 24'sd65451;
      5:  a = 24'sd32757;
      6:  a = 24'sd16383;
      7:  a = 24'sd8192;
      8:  a = 24'sd4096;
      9:  a = 24'sd2048;
      10: a = 24'sd1024;
      11: a = 24'sd512;
      12: a = 24'sd256;
      13: a = 24'sd128;
      14: a = 24'sd64;
      15: a = 24'sd32;
      16: a = 24'sd16;
      17: a = 24'sd8;
      18: a = 24'sd4;
      19: a = 24'sd2;
      20: a = 24'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/core/go_to_goal_heading_controller.sv @@
// top level of the go-to-goal heading controller: configuration registers and pipeline
//
// channel   | handshake        | payload
// ----------+------------------+----------------------------------
// pose in   | start, busy      | pos_x, pos_y, heading
// command   | done (strobe)    | forward_speed, turn_rate
// config    | cfg_we           | cfg_index, cfg_data
//
// one pose request per cycle; a command passes the pre-rotation stage, the one-stage-per-step
// cordic pipeline, and the bearing/distance and command stages. requests taken while either
// target coordinate is not positive give no command. rst is synchronous and clears the stage
// valid bits and loads the configuration defaults; busy is high only during reset. the
// command receiver cannot stall, so nothing holds.
module go_to_goal_heading_controller import ggh_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [HDG_W-1:0] heading,
  output logic                    done,
  output logic [SPD_W-1:0]        forward_speed,
  output logic signed [HDG_W-1:0] turn_rate,
  input  logic                    cfg_we,
  input  reg_idx_t                cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  cfg_t cfg;
  vec_t prep_vec;
  vec_t cordic_vec;
  logic take;

  assign busy = rst;
  assign take = start && !busy && (cfg.target_x > 0) && (cfg.target_y > 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_x <= -24'sd256;
      cfg.target_y <= -24'sd256;
      cfg.max_turn_rate <= 15'd8192;
      cfg.min_turn_rate <= 15'd614;
      cfg.near_distance <= 23'd1280;
      cfg.aligned_error <= 15'd410;
      cfg.fast_speed <= 15'd1024;
      cfg.slow_speed <= 15'd205;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_X:  cfg.target_x <= $signed(cfg_data);
        REG_TARGET_Y:  cfg.target_y <= $signed(cfg_data);
        REG_MAX_TURN:  cfg.max_turn_rate <= cfg_data[SPD_W-1:0];
        REG_MIN_TURN:  cfg.min_turn_rate <= cfg_data[SPD_W-1:0];
        REG_NEAR_DIST: cfg.near_distance <= cfg_data[DIST_W-1:0];
        REG_ALIGNED:   cfg.aligned_error <= cfg_data[SPD_W-1:0];
        REG_FAST:      cfg.fast_speed <= cfg_data[SPD_W-1:0];
        REG_SLOW:      cfg.slow_speed <= cfg_data[SPD_W-1:0];
      endcase
    end
  end

  ggh_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .target_x (cfg.target_x),
    .target_y (cfg.target_y),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .heading  (heading),
    .vec      (prep_vec)
  );

  ggh_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .vec_in  (prep_vec),
    .vec_out (cordic_vec)
  );

  ggh_post u_post (
    .clk           (clk),
    .rst           (rst),
    .vec           (cordic_vec),
    .cfg           (cfg),
    .done          (done),
    .forward_speed (forward_speed),
    .turn_rate     (turn_rate)
  );

endmodule

@@ rtl/core/ggh_prep.sv @@
// goal vector and cordic pre-rotation stage
module ggh_prep import ggh_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  logic signed [POS_W-1:0] target_x,
  input  logic signed [POS_W-1:0] target_y,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [HDG_W-1:0] heading,
  output vec_t                    vec
);

  logic signed [POS_W:0]   dx;
  logic signed [POS_W:0]   dy;
  logic signed [VEC_W-1:0] dx_ext;
  logic signed [VEC_W-1:0] dy_ext;
  vec_t                    vec_next;

  always_comb begin
    dx = $signed({target_x[POS_W-1], target_x}) - $signed({pos_x[POS_W-1], pos_x});
    dy = $signed({target_y[POS_W-1], target_y}) - $signed({pos_y[POS_W-1], pos_y});
    dx_ext = VEC_W'(dx);
    dy_ext = VEC_W'(dy);
    vec_next.valid = take;
    vec_next.on_goal = (dx == '0) && (dy == '0);
    vec_next.hdg = heading;
    if (dx < 0) begin
      vec_next.x = -dx_ext;
      vec_next.y = -dy_ext;
      vec_next.z = (dy >= 0) ? PI_Q20 : -PI_Q20;
    end else begin
      vec_next.x = dx_ext;
      vec_next.y = dy_ext;
      vec_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    vec.on_goal <= vec_next.on_goal;
    vec.hdg <= vec_next.hdg;
    vec.x <= vec_next.x;
    vec.y <= vec_next.y;
    vec.z <= vec_next.z;
    if (rst) begin
      vec.valid <= 1'b0;
    end else begin
      vec.valid <= vec_next.valid;
    end
  end

endmodule

@@ rtl/core/ggh_cordic.sv @@
// pipelined cordic vectoring, one rotation step per stage
module ggh_cordic import ggh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  vec_t vec_in,
  output vec_t vec_out
);

  vec_t st [0:CORDIC_RUN-1];

  for (genvar i = 0; i < CORDIC_RUN; i++) begin : g_step
    vec_t                    src;
    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;

    if (i == 0) begin : g_first
      assign src = vec_in;
    end else begin : g_rest
      assign src = st[i-1];
    end

    assign xs = src.x >>> i;
    assign ys = src.y >>> i;

    always_ff @(posedge clk) begin
      st[i].on_goal <= src.on_goal;
      st[i].hdg <= src.hdg;
      if (src.y >= 0) begin
        st[i].x <= src.x + ys;
        st[i].y <= src.y - xs;
        st[i].z <= src.z + atan_q20(i);
      end else begin
        st[i].x <= src.x - ys;
        st[i].y <= src.y + xs;
        st[i].z <= src.z - atan_q20(i);
      end
      if (rst) begin
        st[i].valid <= 1'b0;
      end else begin
        st[i].valid <= src.valid;
      end
    end
  end

  assign vec_out = st[CORDIC_RUN-1];

endmodule

@@ rtl/core/ggh_post.sv @@
// bearing and distance stage, then heading error, turn clamp and speed select
module ggh_post import ggh_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  vec_t                    vec,
  input  cfg_t                    cfg,
  output logic                    done,
  output logic [SPD_W-1:0]        forward_speed,
  output logic signed [HDG_W-1:0] turn_rate
);

  // stage 1: bearing and distance
  logic signed [ANG_W:0]   z_rnd;
  logic signed [HDG_W-1:0] bearing_next;
  logic [PROD_W-1:0]       prod;
  logic [MAG_W-1:0]        distance_next;

  logic                    s1_valid;
  logic signed [HDG_W-1:0] bearing;
  logic [MAG_W-1:0]        distance;
  logic signed [HDG_W-1:0] hdg;

  always_comb begin
    z_rnd = (ANG_W + 1)'(vec.z) + (ANG_W + 1)'(128);
    bearing_next = HDG_W'(z_rnd >>> 8);
    if (vec.on_goal) begin
      bearing_next = '0;
    end else if (bearing_next < 0) begin
      bearing_next = bearing_next + TWO_PI_Q12;
    end
    prod = PROD_W'(vec.x[MAG_W-1:0]) * PROD_W'(INV_GAIN_Q16) + PROD_W'(32768);
    distance_next = prod[PROD_W-1:GAIN_W];
  end

  always_ff @(posedge clk) begin
    bearing <= bearing_next;
    distance <= distance_next;
    hdg <= vec.hdg;
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= vec.valid;
    end
  end

  // stage 2: heading error and drive command
  logic signed [HDG_W+1:0] err;
  logic signed [HDG_W+1:0] abserr;
  logic signed [HDG_W+2:0] turn_wide;
  logic signed [HDG_W:0]   turn_c;
  logic signed [HDG_W:0]   mx;
  logic signed [HDG_W:0]   mn;
  logic [SPD_W-1:0]        fwd_next;

  always_comb begin
    err = (HDG_W + 2)'(bearing) - (HDG_W + 2)'(hdg);
    if (err < -(HDG_W + 2)'(PI_Q12)) begin
      err = err + (HDG_W + 2)'(TWO_PI_Q12);
    end
    turn_wide = -((HDG_W + 3)'(err) <<< 1);
    if (turn_wide > (HDG_W + 3)'(32767)) begin
      turn_c = (HDG_W + 1)'(32767);
    end else if (turn_wide < -(HDG_W + 3)'(32768)) begin
      turn_c = -(HDG_W + 1)'(32768);
    end else begin
      turn_c = (HDG_W + 1)'(turn_wide);
    end
    mx = $signed({2'b00, cfg.max_turn_rate});
    mn = $signed({2'b00, cfg.min_turn_rate});
    if (turn_c > 0) begin
      if (turn_c > mx) turn_c = mx;
      if (turn_c < mn) turn_c = mn;
    end else begin
      if (turn_c < -mx) turn_c = -mx;
      if (turn_c > -mn) turn_c = -mn;
    end
    abserr = (err < 0) ? -err : err;
    if (distance > MAG_W'(cfg.near_distance)) begin
      fwd_next = (abserr < $signed((HDG_W + 2)'(cfg.aligned_error))) ? cfg.fast_speed
                                                                    : cfg.slow_speed;
    end else begin
      fwd_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    forward_speed <= fwd_next;
    turn_rate <= HDG_W'(turn_c);
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

endmodule

@@ rtl/core/ggh_checker.sv @@
// port-level checks of the go-to-goal heading controller and their bind
module ggh_assertions import ggh_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic                    done,
  input logic signed [HDG_W-1:0] turn_rate
);

  // pipeline is empty right after reset
  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("command strobe right after reset");

  // every command traces back to an earlier request
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("command without matching request");

  // clamp bounds keep the turn rate off the most negative code
  a_turn_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (turn_rate != 16'sh8000))
    else $error("turn rate escaped clamp");

endmodule

bind go_to_goal_heading_controller ggh_assertions u_ggh_assertions (.*);
